@@ design/r2y420_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2y420_pkg
// Shared constants and types for the RGB to YUV 4:2:0 stream converter.
// ----------------------------------------------------------------------------
package r2y420_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int MAX_DIM        = 4096;

  // counter and dimension widths
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = 13;

  localparam int PIX_W = 8;
  // sum width: pixel bits + fraction bits + headroom for three terms and sign
  localparam int SUM_W = PIX_W + COEF_FRAC_BITS + 3;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [PIX_W-1:0]        pix_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] LINE_WIDTH_RST   = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN          = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX          = DIM_W'(MAX_DIM);

  // coefficients, round-half-up of thousandths scaled by 2^COEF_FRAC_BITS
  localparam int K_YR = (298 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_YG = (612 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_YB = (117 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_UR = (168 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_UG = (330 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_UB = (498 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_VR = (449 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_VG = (435 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_VB = ( 83 * (1 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int CHROMA_OFS = 128 * (1 << COEF_FRAC_BITS);

  // floor to integer, clamp to 0..255
  function automatic pix_t fix_to_byte(input sum_t s);
    pix_t res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
      res = '1;
    end else begin
      res = s[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
    return res;
  endfunction

endpackage

@@ design/rgb_to_yuv420_stream_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_stream_unit
// RGB to YUV 4:2:0 conversion of a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per transaction and returns one result per pixel, at a
// sustained rate of one pixel per clock while the result side does not stall, through an
// input register, then the coefficient multiply-add and clamp into the output
// register. Every result carries luma; chroma (U, V) is valid only on the
// top-left pixel of each 2x2 block, flagged in out_tuser, and is zero
// elsewhere. out_tlast marks the last pixel of a frame. Line width and frame
// height are saturated to 2..4096; write them only while the stream is idle.
// A write that leaves the position counters past the new last column or row
// makes the column wrap after the current pixel and the row at the line end.
module rgb_to_yuv420_stream_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input pixels
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [23:0]                           in_tdata,   // red, green, blue
  // results
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [23:0]                           out_tdata,  // luma, blue_diff, red_diff
  output logic                                  out_tuser,  // chroma_valid
  output logic                                  out_tlast,  // frame_end
  // configuration
  input  logic                                  cfg_we,
  input  logic [r2y420_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [r2y420_pkg::DIM_W-1:0]          cfg_wdata
);

  localparam int CW = r2y420_pkg::CNT_W;
  localparam int DW = r2y420_pkg::DIM_W;

  logic [DW-1:0] line_width_r, frame_height_r;
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DW-1:0] w_eff, h_eff;
  logic          last_col, last_row, cvalid;
  logic          in_acc, adv_out;

  // stage 1: registered pixel and position flags
  logic                 s1_vld_r;
  r2y420_pkg::pix_t     s1_red_r, s1_green_r, s1_blue_r;
  logic                 s1_cvalid_r, s1_fend_r;

  // stage 2: output register
  logic                 out_vld_r;
  r2y420_pkg::pix_t     luma_r, udiff_r, vdiff_r;
  r2y420_pkg::pix_t     luma_nxt, udiff_nxt, vdiff_nxt;
  logic                 cvalid_r, fend_r;

  r2y420_pkg::sum_t     r_s, g_s, b_s, y_sum, u_sum, v_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= r2y420_pkg::LINE_WIDTH_RST;
      frame_height_r <= r2y420_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        r2y420_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        r2y420_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width_r < r2y420_pkg::DIM_MIN) begin
      w_eff = r2y420_pkg::DIM_MIN;
    end else if (line_width_r > r2y420_pkg::DIM_MAX) begin
      w_eff = r2y420_pkg::DIM_MAX;
    end else begin
      w_eff = line_width_r;
    end
    if (frame_height_r < r2y420_pkg::DIM_MIN) begin
      h_eff = r2y420_pkg::DIM_MIN;
    end else if (frame_height_r > r2y420_pkg::DIM_MAX) begin
      h_eff = r2y420_pkg::DIM_MAX;
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign adv_out   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv_out;
  assign in_acc    = in_tvalid && in_tready;

  // position tracking
  assign last_col = (DW'(col_r) + DW'(1)) >= w_eff;
  assign last_row = (DW'(row_r) + DW'(1)) >= h_eff;
  assign cvalid   = !col_r[0] && !row_r[0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + CW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_red_r    <= in_tdata[7:0];
      s1_green_r  <= in_tdata[15:8];
      s1_blue_r   <= in_tdata[23:16];
      s1_cvalid_r <= cvalid;
      s1_fend_r   <= last_col && last_row;
    end
  end

  // color matrix
  assign r_s = r2y420_pkg::sum_t'(s1_red_r);
  assign g_s = r2y420_pkg::sum_t'(s1_green_r);
  assign b_s = r2y420_pkg::sum_t'(s1_blue_r);

  assign y_sum = r2y420_pkg::sum_t'(r2y420_pkg::K_YR) * r_s
               + r2y420_pkg::sum_t'(r2y420_pkg::K_YG) * g_s
               + r2y420_pkg::sum_t'(r2y420_pkg::K_YB) * b_s;
  assign u_sum = r2y420_pkg::sum_t'(r2y420_pkg::CHROMA_OFS)
               + r2y420_pkg::sum_t'(r2y420_pkg::K_UB) * b_s
               - r2y420_pkg::sum_t'(r2y420_pkg::K_UR) * r_s
               - r2y420_pkg::sum_t'(r2y420_pkg::K_UG) * g_s;
  assign v_sum = r2y420_pkg::sum_t'(r2y420_pkg::CHROMA_OFS)
               + r2y420_pkg::sum_t'(r2y420_pkg::K_VR) * r_s
               - r2y420_pkg::sum_t'(r2y420_pkg::K_VG) * g_s
               - r2y420_pkg::sum_t'(r2y420_pkg::K_VB) * b_s;

  assign luma_nxt  = r2y420_pkg::fix_to_byte(y_sum);
  assign udiff_nxt = s1_cvalid_r ? r2y420_pkg::fix_to_byte(u_sum) : '0;
  assign vdiff_nxt = s1_cvalid_r ? r2y420_pkg::fix_to_byte(v_sum) : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv_out) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_vld_r) begin
      luma_r   <= luma_nxt;
      udiff_r  <= udiff_nxt;
      vdiff_r  <= vdiff_nxt;
      cvalid_r <= s1_cvalid_r;
      fend_r   <= s1_fend_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {vdiff_r, udiff_r, luma_r};
  assign out_tuser  = cvalid_r;
  assign out_tlast  = fend_r;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB to YUV 4:2:0 stream converter.
// ----------------------------------------------------------------------------
// Sends raster-order RGB pixels with random gaps and applies random stalls on
// the result side. A local model of the color math and of the column and row
// counters predicts luma, chroma, the chroma flag and the frame-end flag for
// every pixel. Line width and frame height are rewritten between bursts while
// the counters sit mid-frame, including out-of-range and odd values.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int BURST_LEN      = 80;
  localparam int LONG_RUN_LEN   = 170;
  localparam int DW             = r2y420_pkg::DIM_W;
  localparam int IW             = r2y420_pkg::CFG_IDX_W;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       chroma_valid;
    logic       frame_end;
  } pixel_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // red, green, blue
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // luma, blue_diff, red_diff
  logic                 out_tuser;  // chroma_valid
  logic                 out_tlast;  // frame_end
  logic                 cfg_we;
  logic [IW-1:0]        cfg_index;
  logic [DW-1:0]        cfg_wdata;

  pixel_result_t        expected_pixels[$];
  int                   err_count;
  int                   idle_cycles;
  bit                   idle_en;

  // model copy of registers and raster position
  logic [DW-1:0]        width_reg;
  logic [DW-1:0]        height_reg;
  int                   pos_col;
  int                   pos_row;

  rgb_to_yuv420_stream_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [DW-1:0] v);
    if (int'(v) < 2) return 2;
    if (int'(v) > r2y420_pkg::MAX_DIM) return r2y420_pkg::MAX_DIM;
    return int'(v);
  endfunction

  // floor then saturate to one byte
  function automatic logic [7:0] sum_to_byte(input longint s);
    longint q;
    if (s < 0) return 8'd0;
    q = s >> r2y420_pkg::COEF_FRAC_BITS;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [7:0] r, g, b);
    longint        lr, lg, lb, sy, su, sv;
    int            w, h;
    logic          last_col, last_row;
    pixel_result_t res;
    lr = longint'(r);
    lg = longint'(g);
    lb = longint'(b);
    w  = clamp_dim(width_reg);
    h  = clamp_dim(height_reg);
    last_col = (pos_col + 1 >= w);
    last_row = (pos_row + 1 >= h);
    sy = longint'(r2y420_pkg::K_YR) * lr + longint'(r2y420_pkg::K_YG) * lg
         + longint'(r2y420_pkg::K_YB) * lb;
    su = longint'(r2y420_pkg::CHROMA_OFS) + longint'(r2y420_pkg::K_UB) * lb
         - longint'(r2y420_pkg::K_UR) * lr - longint'(r2y420_pkg::K_UG) * lg;
    sv = longint'(r2y420_pkg::CHROMA_OFS) + longint'(r2y420_pkg::K_VR) * lr
         - longint'(r2y420_pkg::K_VG) * lg - longint'(r2y420_pkg::K_VB) * lb;
    res.luma         = sum_to_byte(sy);
    res.chroma_valid = (pos_col[0] == 1'b0) && (pos_row[0] == 1'b0);
    res.blue_diff    = res.chroma_valid ? sum_to_byte(su) : 8'd0;
    res.red_diff     = res.chroma_valid ? sum_to_byte(sv) : 8'd0;
    res.frame_end    = last_col && last_row;
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b);
    int gap;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {b, g, r};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_pixels.push_back(predict_pixel(r, g, b));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == r2y420_pkg::REG_LINE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_component();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // reset dimensions 640x480 stay in effect
  task automatic test_reset_defaults();
    idle_en = 1'b1;
    repeat (6) send_pixel(rand_component(), rand_component(), rand_component());
  endtask

  // color cube corners: luma overflow, mid gray
  task automatic test_color_extremes();
    wait_idle();
    write_reg(r2y420_pkg::REG_LINE_WIDTH, 13'd2);
    write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 13'd2);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  // zero and one saturate up to two
  task automatic test_dimension_floor();
    wait_idle();
    write_reg(r2y420_pkg::REG_LINE_WIDTH, 13'd0);
    write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 13'd1);
    repeat (5) send_pixel(rand_component(), rand_component(), rand_component());
  endtask

  // all-ones width saturates to the maximum; a long run stays on one line
  task automatic test_full_width_line();
    wait_idle();
    write_reg(r2y420_pkg::REG_LINE_WIDTH, 13'h1FFF);
    write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 13'd2);
    idle_en = 1'b0;
    repeat (LONG_RUN_LEN) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // bursts under varied settings, counters carried across each rewrite
  task automatic test_random_settings();
    int widths[12]  = '{2, 3, 4, 1, 6, 5, 2, 8191, 16, 7, 4097, 640};
    int heights[12] = '{2, 3, 2, 5, 4, 7, 4096, 0, 6, 2, 8191, 480};
    for (int i = 0; i < 12; i++) begin
      wait_idle();
      write_reg(r2y420_pkg::REG_LINE_WIDTH, DW'(widths[i]));
      write_reg(r2y420_pkg::REG_FRAME_HEIGHT, DW'(heights[i]));
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (BURST_LEN) send_pixel(rand_component(), rand_component(), rand_component());
    end
  endtask

  // result side back-pressure
  initial begin : result_ready
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = idle_en ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected transaction, luma", int'(out_tdata[7:0]), -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[7:0] !== want.luma)
          report_mismatch("luma", int'(out_tdata[7:0]), int'(want.luma));
        if (out_tdata[15:8] !== want.blue_diff)
          report_mismatch("blue_diff", int'(out_tdata[15:8]), int'(want.blue_diff));
        if (out_tdata[23:16] !== want.red_diff)
          report_mismatch("red_diff", int'(out_tdata[23:16]), int'(want.red_diff));
        if (out_tuser !== want.chroma_valid)
          report_mismatch("chroma_valid", int'(out_tuser), int'(want.chroma_valid));
        if (out_tlast !== want.frame_end)
          report_mismatch("frame_end", int'(out_tlast), int'(want.frame_end));
      end
    end
  end

  // stop on a long stretch without any transaction
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = r2y420_pkg::REG_LINE_WIDTH;
    cfg_wdata  = '0;
    err_count  = 0;
    idle_en    = 1'b1;
    width_reg  = r2y420_pkg::LINE_WIDTH_RST;
    height_reg = r2y420_pkg::FRAME_HEIGHT_RST;
    pos_col    = 0;
    pos_row    = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_color_extremes();
    test_dimension_floor();
    test_full_width_line();
    test_random_settings();

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
